FILE: rtl/htc_pkg.sv
package htc_pkg;

	// Event codes carried in the action field
	localparam logic [2:0] ACT_POWER  = 3'd0;
	localparam logic [2:0] ACT_UP     = 3'd1;
	localparam logic [2:0] ACT_DOWN   = 3'd2;
	localparam logic [2:0] ACT_SAMPLE = 3'd3;
	localparam logic [2:0] ACT_SECOND = 3'd4;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_MIN_SP    = 3'd0;
	localparam logic [2:0] REG_MAX_SP    = 3'd1;
	localparam logic [2:0] REG_STEP      = 3'd2;
	localparam logic [2:0] REG_BAND      = 3'd3;
	localparam logic [2:0] REG_TIMEOUT   = 3'd4;
	localparam logic [2:0] REG_DEFAULT   = 3'd5;
	localparam logic [2:0] REG_BLINK     = 3'd6;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Register reset values
	localparam logic [6:0] MIN_SP_RST  = 7'd35;
	localparam logic [6:0] MAX_SP_RST  = 7'd75;
	localparam logic [3:0] STEP_RST    = 4'd5;
	localparam logic [5:0] BAND_RST    = 6'd5;
	localparam logic [3:0] TIMEOUT_RST = 4'd5;
	localparam logic [6:0] DEFAULT_RST = 7'd60;
	localparam logic [3:0] BLINK_RST   = 4'd2;

	typedef struct packed {
		logic [6:0] min_setpoint;
		logic [6:0] max_setpoint;
		logic [3:0] setpoint_step;
		logic [5:0] hysteresis_band;
		logic [3:0] edit_timeout;
		logic [6:0] default_setpoint;
		logic [3:0] blink_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] raw_sample;
	} event_t;

	typedef struct packed {
		logic       power_on;
		logic       heater_on;
		logic       cooler_on;
		logic       indicator_led;
		logic [6:0] display_value;
		logic       display_visible;
		logic [6:0] average_temp;
		logic       save_strobe;
	} result_t;

endpackage

FILE: rtl/htc_stream_if.sv
interface htc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/htc_cell.sv
module htc_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fill,
	input  logic [6:0] fill_value,
	input  logic       shift,
	input  logic [6:0] d,
	output logic [6:0] q
);
	import htc_pkg::*;

	logic [6:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= DEFAULT_RST;
		end else if (fill) begin
			sample_q <= fill_value;
		end else if (shift) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

FILE: rtl/htc_chain.sv
module htc_chain #(
	parameter int DEPTH = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fill,
	input  logic [6:0] fill_value,
	input  logic       shift,
	input  logic [6:0] sample,
	output logic [6:0] avg
);
	import htc_pkg::*;

	localparam int SUM_W  = $clog2(DEPTH * 127 + 1);
	// reciprocal is exact for every sum below 2**SUM_W
	localparam int K      = SUM_W + 7;
	localparam int RECIP  = ((2 ** K) + DEPTH - 1) / DEPTH;
	localparam int PROD_W = SUM_W + K;

	logic [6:0]        tap [DEPTH+1];
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sum_nx;
	logic [PROD_W-1:0] prod;

	assign tap[0] = sample;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		htc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.fill       (fill),
			.fill_value (fill_value),
			.shift      (shift),
			.d          (tap[i]),
			.q          (tap[i+1])
		);
	end

	// oldest sample falls off the end of the chain
	assign sum_nx = shift ? (sum_q - SUM_W'(tap[DEPTH]) + SUM_W'(sample)) : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= SUM_W'(DEPTH) * SUM_W'(DEFAULT_RST);
		end else if (fill) begin
			sum_q <= SUM_W'(DEPTH) * SUM_W'(fill_value);
		end else begin
			sum_q <= sum_nx;
		end
	end

	assign prod = PROD_W'(sum_nx) * PROD_W'(RECIP);
	assign avg  = prod[K +: 7];

endmodule

FILE: rtl/htc_regs.sv
module htc_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [htc_pkg::ADDR_W-1:0] paddr,
	input  logic [htc_pkg::DATA_W-1:0] pwdata,
	output logic [htc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output htc_pkg::cfg_t              cfg,
	output logic                       seed
);
	import htc_pkg::*;

	cfg_t       cfg_q;
	logic       wr;
	logic [2:0] idx;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign seed   = wr && (idx == REG_DEFAULT);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_setpoint     <= MIN_SP_RST;
			cfg_q.max_setpoint     <= MAX_SP_RST;
			cfg_q.setpoint_step    <= STEP_RST;
			cfg_q.hysteresis_band  <= BAND_RST;
			cfg_q.edit_timeout     <= TIMEOUT_RST;
			cfg_q.default_setpoint <= DEFAULT_RST;
			cfg_q.blink_ticks      <= BLINK_RST;
		end else if (wr) begin
			unique case (idx)
				REG_MIN_SP:  cfg_q.min_setpoint     <= pwdata[6:0];
				REG_MAX_SP:  cfg_q.max_setpoint     <= pwdata[6:0];
				REG_STEP:    cfg_q.setpoint_step    <= pwdata[3:0];
				REG_BAND:    cfg_q.hysteresis_band  <= pwdata[5:0];
				REG_TIMEOUT: cfg_q.edit_timeout     <= pwdata[3:0];
				REG_DEFAULT: cfg_q.default_setpoint <= pwdata[6:0];
				REG_BLINK:   cfg_q.blink_ticks      <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MIN_SP:  prdata = DATA_W'(cfg_q.min_setpoint);
			REG_MAX_SP:  prdata = DATA_W'(cfg_q.max_setpoint);
			REG_STEP:    prdata = DATA_W'(cfg_q.setpoint_step);
			REG_BAND:    prdata = DATA_W'(cfg_q.hysteresis_band);
			REG_TIMEOUT: prdata = DATA_W'(cfg_q.edit_timeout);
			REG_DEFAULT: prdata = DATA_W'(cfg_q.default_setpoint);
			REG_BLINK:   prdata = DATA_W'(cfg_q.blink_ticks);
			default:     prdata = '0;
		endcase
	end

endmodule

FILE: rtl/hysteresis_thermostat_controller.sv
// Hysteresis thermostat controller. Each request on evt is one event (power press,
// up/down press, sample tick with a converter reading, one-second tick) and yields
// exactly one result on res. A request is taken every clock cycle that evt.ready is
// high: the whole state update, including the running-sum update of the sample
// history, the constant reciprocal multiply that forms the average and the band
// compare, is combinational and its result is registered. Results pass through a
// two-entry output buffer, so evt stays ready while one result waits on res;
// evt.ready drops only when both entries are full. The history is a chain of
// HISTORY_DEPTH sample cells that shift on each sample tick taken while powered;
// writing default_setpoint reloads every cell in the same cycle, so there is no
// clearing pass after reset. Registers sit on an APB port at byte address 4*index.
module hysteresis_thermostat_controller #(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [htc_pkg::ADDR_W-1:0] paddr,
	input  logic [htc_pkg::DATA_W-1:0] pwdata,
	output logic [htc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	htc_stream_if.sink                 evt,
	htc_stream_if.source               res
);
	import htc_pkg::*;

	cfg_t       cfg;
	logic       seed;

	// thermostat state
	logic       powered_q, editing_q, heating_q, cooling_q;
	logic       disp_mask_q, led_mask_q, saved_valid_q;
	logic [3:0] idle_q, disp_cnt_q, led_cnt_q;
	logic [6:0] setpoint_q, cur_temp_q, saved_sp_q;

	// next-state values
	logic       powered_n, editing_n, heating_n, cooling_n;
	logic       disp_mask_n, led_mask_n, saved_valid_n, strobe;
	logic [3:0] idle_n, disp_cnt_n, led_cnt_n, idle_inc, disp_inc, led_inc;
	logic [6:0] setpoint_n, cur_temp_n, saved_sp_n, avg;
	logic [7:0] sp_up;
	logic signed [8:0] diff, band;

	// output buffer: out entry drives res, skid entry catches one more
	result_t    res_nx, out_q, skid_q;
	logic       out_valid_q, skid_valid_q;

	logic       accept, pop, shift;
	event_t     ev;

	assign ev     = evt.data;
	assign accept = evt.valid && evt.ready;
	assign pop    = out_valid_q && res.ready;
	assign shift  = accept && powered_q && (ev.action == ACT_SAMPLE);

	assign evt.ready = !skid_valid_q;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	htc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.seed    (seed)
	);

	htc_chain #(
		.DEPTH (HISTORY_DEPTH)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.fill       (seed),
		.fill_value (pwdata[6:0]),
		.shift      (shift),
		.sample     (ev.raw_sample[7:1]),
		.avg        (avg)
	);

	always_comb begin
		powered_n     = powered_q;
		editing_n     = editing_q;
		heating_n     = heating_q;
		cooling_n     = cooling_q;
		disp_mask_n   = disp_mask_q;
		led_mask_n    = led_mask_q;
		saved_valid_n = saved_valid_q;
		idle_n        = idle_q;
		disp_cnt_n    = disp_cnt_q;
		led_cnt_n     = led_cnt_q;
		setpoint_n    = setpoint_q;
		cur_temp_n    = cur_temp_q;
		saved_sp_n    = saved_sp_q;
		strobe        = 1'b0;

		sp_up    = {1'b0, setpoint_q} + {4'b0, cfg.setpoint_step};
		idle_inc = (editing_q && (idle_q < cfg.edit_timeout)) ? idle_q + 4'd1 : idle_q;
		disp_inc = disp_cnt_q + 4'd1;
		led_inc  = led_cnt_q + 4'd1;

		case (ev.action) inside
			ACT_POWER: begin
				// power-on restores the last saved setpoint; power-off keeps state
				powered_n = !powered_q;
				if (!powered_q && saved_valid_q) begin
					setpoint_n = saved_sp_q;
				end
			end
			ACT_UP, ACT_DOWN: begin
				if (powered_q) begin
					idle_n = '0;
					if (!editing_q) begin
						// first press only opens edit mode
						editing_n = 1'b1;
					end else if (ev.action == ACT_UP) begin
						if (setpoint_q < cfg.max_setpoint) begin
							setpoint_n = sp_up[7] ? 7'h7F : sp_up[6:0];
						end
					end else if (setpoint_q > cfg.min_setpoint) begin
						setpoint_n = (setpoint_q >= 7'(cfg.setpoint_step)) ?
							setpoint_q - 7'(cfg.setpoint_step) : 7'd0;
					end
				end
			end
			ACT_SAMPLE: begin
				if (powered_q) begin
					if (editing_q) begin
						disp_cnt_n = disp_inc;
						if (disp_inc >= cfg.blink_ticks) begin
							disp_mask_n = !disp_mask_q;
							disp_cnt_n  = '0;
						end
					end
					if (heating_q) begin
						led_cnt_n = led_inc;
						if (led_inc >= cfg.blink_ticks) begin
							led_mask_n = !led_mask_q;
							led_cnt_n  = '0;
						end
					end
					cur_temp_n = ev.raw_sample[7:1];
				end
			end
			ACT_SECOND: begin
				if (powered_q) begin
					idle_n = idle_inc;
					// timeout: leave edit mode and save the setpoint
					if (editing_q && (idle_inc >= cfg.edit_timeout)) begin
						editing_n     = 1'b0;
						idle_n        = '0;
						disp_mask_n   = 1'b1;
						saved_sp_n    = setpoint_q;
						saved_valid_n = 1'b1;
						strobe        = 1'b1;
					end
				end
			end
			default: ;
		endcase

		// hysteresis choice; inside the band the previous choice holds
		diff = $signed({2'b00, setpoint_n}) - $signed({2'b00, avg});
		band = $signed({3'b000, cfg.hysteresis_band});
		if (powered_n) begin
			if (diff >= band) begin
				heating_n = 1'b1;
				cooling_n = 1'b0;
			end else if (diff <= -band) begin
				heating_n = 1'b0;
				cooling_n = 1'b1;
			end
		end

		res_nx.power_on        = powered_n;
		res_nx.heater_on       = powered_n && heating_n;
		res_nx.cooler_on       = powered_n && cooling_n;
		res_nx.indicator_led   = powered_n && (heating_n || cooling_n) && led_mask_n;
		res_nx.display_value   = editing_n ? setpoint_n : cur_temp_n;
		res_nx.display_visible = powered_n && disp_mask_n;
		res_nx.average_temp    = avg;
		res_nx.save_strobe     = strobe;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			powered_q     <= 1'b0;
			editing_q     <= 1'b0;
			heating_q     <= 1'b0;
			cooling_q     <= 1'b0;
			disp_mask_q   <= 1'b1;
			led_mask_q    <= 1'b1;
			saved_valid_q <= 1'b0;
			idle_q        <= '0;
			disp_cnt_q    <= '0;
			led_cnt_q     <= '0;
			setpoint_q    <= DEFAULT_RST;
			cur_temp_q    <= '0;
			saved_sp_q    <= '0;
		end else if (seed) begin
			setpoint_q <= pwdata[6:0];
		end else if (accept) begin
			powered_q     <= powered_n;
			editing_q     <= editing_n;
			heating_q     <= heating_n;
			cooling_q     <= cooling_n;
			disp_mask_q   <= disp_mask_n;
			led_mask_q    <= led_mask_n;
			saved_valid_q <= saved_valid_n;
			idle_q        <= idle_n;
			disp_cnt_q    <= disp_cnt_n;
			led_cnt_q     <= led_cnt_n;
			setpoint_q    <= setpoint_n;
			cur_temp_q    <= cur_temp_n;
			saved_sp_q    <= saved_sp_n;
		end
	end

	// two-entry result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_valid_q && !pop) begin
				skid_q <= res_nx;
			end else begin
				out_q <= res_nx;
			end
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");

	a_heat_cool_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(heating_q && cooling_q))
		else $error("heating and cooling both set");

	a_idle_only_editing: assert property (@(posedge clk) disable iff (!arst_n)
		!editing_q |-> (idle_q == 4'd0))
		else $error("idle counter running outside edit mode");

	a_save_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.save_strobe) |->
			(res.data.power_on && res.data.display_visible))
		else $error("save reported without visible powered display");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import htc_pkg::*;

	localparam int HIST_DEPTH = 10;

	// Spare action codes: the block must leave its state alone on these
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
	// No register lives here; a write must be ignored
	localparam logic [2:0] REG_UNUSED      = 3'd7;

	localparam int RESET_CYCLES = 11;
	localparam int SETTLE_CYCLES = 4;   // covers the registered result plus the output buffer
	localparam int MAX_STALL = 12;      // longest run of res.ready low
	localparam int PHASE_ITEMS = 150;
	localparam int PHASES = 6;
	localparam int ERR_SHOWN = 10;

	typedef enum int {PICK_LOW, PICK_HIGH, PICK_RAND} cfg_pick_e;
	typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [ADDR_W-1:0]   paddr   = '0;
	logic [DATA_W-1:0]   pwdata  = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	htc_stream_if #(.T(event_t))  evt_if ();
	htc_stream_if #(.T(result_t)) res_if ();

	hysteresis_thermostat_controller #(
		.HISTORY_DEPTH(HIST_DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.evt     (evt_if),
		.res     (res_if)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Thermostat predictor: own copy of the registers and of the state
	// ------------------------------------------------------------------
	cfg_t       cfg;
	bit         powered, editing, heating, cooling;
	bit         disp_mask, led_mask, saved_valid;
	logic [3:0] idle_secs, disp_cnt, led_cnt;
	logic [6:0] setpoint, cur_temp, saved_sp;
	logic [6:0] hist [HIST_DEPTH];
	int         wr_pos;
	logic [10:0] hist_sum;

	// Loading the default setpoint refills the whole history with it
	function automatic void reseed_history();
		setpoint = cfg.default_setpoint;
		for (int k = 0; k < HIST_DEPTH; k++)
			hist[k] = cfg.default_setpoint;
		hist_sum = 11'(HIST_DEPTH * int'(cfg.default_setpoint));
		wr_pos = 0;
	endfunction

	function automatic void predictor_reset();
		cfg.min_setpoint     = MIN_SP_RST;
		cfg.max_setpoint     = MAX_SP_RST;
		cfg.setpoint_step    = STEP_RST;
		cfg.hysteresis_band  = BAND_RST;
		cfg.edit_timeout     = TIMEOUT_RST;
		cfg.default_setpoint = DEFAULT_RST;
		cfg.blink_ticks      = BLINK_RST;
		powered = 0; editing = 0; heating = 0; cooling = 0;
		disp_mask = 1; led_mask = 1; saved_valid = 0;
		idle_secs = '0; disp_cnt = '0; led_cnt = '0;
		cur_temp = '0; saved_sp = '0;
		reseed_history();
	endfunction

	function automatic void cfg_apply(logic [2:0] idx, logic [31:0] v);
		case (idx)
			REG_MIN_SP:  cfg.min_setpoint    = v[6:0];
			REG_MAX_SP:  cfg.max_setpoint    = v[6:0];
			REG_STEP:    cfg.setpoint_step   = v[3:0];
			REG_BAND:    cfg.hysteresis_band = v[5:0];
			REG_TIMEOUT: cfg.edit_timeout    = v[3:0];
			REG_DEFAULT: begin
				cfg.default_setpoint = v[6:0];
				reseed_history();
			end
			REG_BLINK:   cfg.blink_ticks     = v[3:0];
			default: ;
		endcase
	endfunction

	// Advance the predicted state by one event and return the status it yields
	function automatic result_t thermostat_predict(event_t ev);
		result_t r;
		int      sp_next, avg, diff, band;
		bit      strobe;
		strobe = 0;
		case (ev.action)
			ACT_POWER: begin
				if (!powered) begin
					powered = 1;
					if (saved_valid)
						setpoint = saved_sp;
				end else begin
					// switching off keeps every other piece of state
					powered = 0;
				end
			end
			ACT_UP, ACT_DOWN: begin
				if (powered) begin
					idle_secs = '0;
					if (!editing) begin
						// first press only opens edit mode
						editing = 1;
					end else if (ev.action == ACT_UP) begin
						if (setpoint < cfg.max_setpoint) begin
							sp_next = int'(setpoint) + int'(cfg.setpoint_step);
							setpoint = (sp_next > 127) ? 7'd127 : 7'(sp_next);
						end
					end else begin
						if (setpoint > cfg.min_setpoint) begin
							sp_next = int'(setpoint) - int'(cfg.setpoint_step);
							setpoint = (sp_next < 0) ? 7'd0 : 7'(sp_next);
						end
					end
				end
			end
			ACT_SAMPLE: begin
				if (powered) begin
					if (editing) begin
						disp_cnt = disp_cnt + 4'd1;
						if (disp_cnt >= cfg.blink_ticks) begin
							disp_mask = !disp_mask;
							disp_cnt = '0;
						end
					end
					if (heating) begin
						led_cnt = led_cnt + 4'd1;
						if (led_cnt >= cfg.blink_ticks) begin
							led_mask = !led_mask;
							led_cnt = '0;
						end
					end
					cur_temp = ev.raw_sample[7:1];
					hist_sum = hist_sum - 11'(hist[wr_pos]) + 11'(cur_temp);
					hist[wr_pos] = cur_temp;
					wr_pos = (wr_pos + 1 >= HIST_DEPTH) ? 0 : wr_pos + 1;
				end
			end
			ACT_SECOND: begin
				if (powered) begin
					if (editing && idle_secs < cfg.edit_timeout)
						idle_secs = idle_secs + 4'd1;
					// a timeout of zero closes the edit on the first tick
					if (editing && idle_secs >= cfg.edit_timeout) begin
						editing = 0;
						idle_secs = '0;
						disp_mask = 1;
						saved_sp = setpoint;
						saved_valid = 1;
						strobe = 1;
					end
				end
			end
			default: ;
		endcase

		avg = int'(hist_sum) / HIST_DEPTH;

		// inside the band the previous choice holds
		if (powered) begin
			diff = int'(setpoint) - avg;
			band = int'(cfg.hysteresis_band);
			if (diff >= band) begin
				heating = 1;
				cooling = 0;
			end else if (diff <= -band) begin
				heating = 0;
				cooling = 1;
			end
		end

		r.power_on        = powered;
		r.heater_on       = powered && heating;
		r.cooler_on       = powered && cooling;
		r.indicator_led   = powered && (heating || cooling) && led_mask;
		r.display_value   = editing ? setpoint : cur_temp;
		r.display_visible = powered && disp_mask;
		r.average_temp    = 7'(avg);
		r.save_strobe     = strobe;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Event driver: requests leave in bursts with random gaps
	// ------------------------------------------------------------------
	event_t  pending_events_q [$];
	result_t expected_status_q [$];
	int      gap_left = 0;
	int      burst_left = 1;

	always @(posedge clk) begin
		if (!arst_n) begin
			evt_if.valid <= 1'b0;
		end else begin
			if (evt_if.valid && evt_if.ready) begin
				expected_status_q.push_back(thermostat_predict(evt_if.data));
			end
			if (!evt_if.valid || evt_if.ready) begin
				if (gap_left > 0 || pending_events_q.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					evt_if.valid <= 1'b0;
				end else begin
					evt_if.valid <= 1'b1;
					evt_if.data  <= pending_events_q.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// a quarter of bursts run straight into the next one
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Status monitor: checks each result against the oldest prediction
	// ------------------------------------------------------------------
	int       status_errors = 0;
	result_t  want;
	rx_mode_e rx_mode = RX_FLOW;
	int       rx_mode_left = 0;
	int       stall_run = 0;
	bit       take;

	function automatic string fmt_status(result_t s);
		return $sformatf("pwr=%0b heat=%0b cool=%0b led=%0b disp=%0d vis=%0b avg=%0d save=%0b",
			s.power_on, s.heater_on, s.cooler_on, s.indicator_led,
			s.display_value, s.display_visible, s.average_temp, s.save_strobe);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (expected_status_q.size() == 0) begin
					if (status_errors < ERR_SHOWN)
						$display("ERROR: unexpected status %s", fmt_status(res_if.data));
					status_errors++;
				end else begin
					want = expected_status_q.pop_front();
					if (res_if.data !== want) begin
						if (status_errors < ERR_SHOWN) begin
							$display("ERROR: status mismatch at %0t", $realtime);
							$display("  expected %s", fmt_status(want));
							$display("  actual   %s", fmt_status(res_if.data));
						end
						status_errors++;
					end
				end
			end

			// receiver back-pressure: free flow, light or heavy stalling, in stretches
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 2));
				rx_mode_left = $urandom_range(16, 96);
			end else begin
				rx_mode_left--;
			end
			case (rx_mode)
				RX_FLOW:  take = 1'b1;
				RX_LIGHT: take = ($urandom_range(0, 9) < 7);
				default:  take = ($urandom_range(0, 9) < 3);
			endcase
			if (stall_run >= MAX_STALL)
				take = 1'b1;
			stall_run = take ? 0 : stall_run + 1;
			res_if.ready <= take;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	bit gen_powered = 0;   // power state as seen by the generator

	// Queue one event; returns 1 when the block actually acts on it
	function automatic int queue_event(logic [2:0] act, logic [7:0] raw);
		event_t ev;
		int     live;
		ev.action = act;
		ev.raw_sample = raw;
		pending_events_q.push_back(ev);
		live = int'((act == ACT_POWER) || (gen_powered && act <= ACT_SECOND));
		if (act == ACT_POWER)
			gen_powered = !gen_powered;
		return live;
	endfunction

	function automatic logic [31:0] pick_reg(logic [2:0] idx, cfg_pick_e mode);
		int          top, bottom, width;
		logic [31:0] v;
		case (idx)
			REG_MIN_SP, REG_MAX_SP, REG_DEFAULT: begin
				top = 127; bottom = 0; width = 7;
			end
			REG_BAND: begin
				top = 63; bottom = 1; width = 6;
			end
			default: begin
				top = 15; bottom = 1; width = 4;
			end
		endcase
		case (mode)
			PICK_LOW:  v = bottom;
			PICK_HIGH: v = top;
			default:   v = $urandom_range(0, top);
		endcase
		// bits above the field must be dropped by the block
		if ($urandom_range(0, 1) == 1)
			v = v | ($urandom() << width);
		return v;
	endfunction

	// Register write over APB; only called with the block idle
	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_apply(idx, val);
	endtask

	// Hold off until every request has gone and every status has come back
	task automatic drain();
		while (pending_events_q.size() != 0 || evt_if.valid || expected_status_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random events in runs: press runs, sample runs and second-tick runs long
	// enough to reach any edit timeout, with a little noise mixed in
	task automatic gen_events(input int target);
		int counted, n, r;
		counted = 0;
		while (counted < target) begin
			if (!gen_powered) begin
				if ($urandom_range(0, 9) < 8)
					counted += queue_event(ACT_POWER, 8'($urandom()));
				else
					counted += queue_event(3'($urandom_range(1, 7)), 8'($urandom()));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					counted += queue_event(ACT_POWER, 8'($urandom()));
				end else if (r < 8) begin
					counted += queue_event(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)),
						8'($urandom()));
				end else if (r < 35) begin
					n = $urandom_range(1, 5);
					repeat (n)
						counted += queue_event($urandom_range(0, 1) ? ACT_UP : ACT_DOWN,
							8'($urandom()));
				end else if (r < 70) begin
					n = $urandom_range(1, 10);
					repeat (n) begin
						case ($urandom_range(0, 7))
							0:       counted += queue_event(ACT_SAMPLE, 8'h00);
							1:       counted += queue_event(ACT_SAMPLE, 8'hFF);
							default: counted += queue_event(ACT_SAMPLE, 8'($urandom()));
						endcase
					end
				end else begin
					n = $urandom_range(1, 17);
					repeat (n)
						counted += queue_event(ACT_SECOND, 8'($urandom()));
				end
			end
		end
	endtask

	initial begin
		int        dummy;
		cfg_pick_e mode;
		evt_if.valid = 1'b0;
		evt_if.data  = '0;
		res_if.ready = 1'b0;
		predictor_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset settings: ignored while off, first press, step to the
		// upper limit, sample extremes, edit timeout with save, spare codes,
		// power cycle that reloads the saved setpoint
		@(negedge clk);
		dummy = queue_event(ACT_UP, 8'hFF);
		dummy = queue_event(ACT_SAMPLE, 8'hAA);
		dummy = queue_event(ACT_SECOND, 8'h00);
		dummy = queue_event(ACT_POWER, 8'h00);
		dummy = queue_event(ACT_DOWN, 8'h00);
		repeat (4) dummy = queue_event(ACT_UP, 8'h00);
		dummy = queue_event(ACT_SAMPLE, 8'hFF);
		dummy = queue_event(ACT_SAMPLE, 8'h00);
		dummy = queue_event(ACT_SAMPLE, 8'h01);
		repeat (5) dummy = queue_event(ACT_SECOND, 8'h00);
		dummy = queue_event(ACT_SPARE_FIRST, 8'h55);
		dummy = queue_event(ACT_SPARE_LAST, 8'hAA);
		dummy = queue_event(ACT_POWER, 8'h00);
		dummy = queue_event(ACT_POWER, 8'h00);
		drain();

		// Directed, wide limits: step past 127, blink every tick, timeout of zero
		apb_write(REG_MIN_SP, 32'd0);
		apb_write(REG_MAX_SP, 32'd127);
		apb_write(REG_STEP, 32'd15);
		apb_write(REG_BAND, 32'd63);
		apb_write(REG_TIMEOUT, 32'd0);
		apb_write(REG_BLINK, 32'd0);
		apb_write(REG_DEFAULT, 32'd120);
		@(negedge clk);
		dummy = queue_event(ACT_UP, 8'h00);
		dummy = queue_event(ACT_UP, 8'h00);
		dummy = queue_event(ACT_SAMPLE, 8'hFE);
		dummy = queue_event(ACT_SAMPLE, 8'h02);
		dummy = queue_event(ACT_SECOND, 8'h00);
		drain();

		// Directed: step below zero, then a press that sits at the lower limit
		apb_write(REG_DEFAULT, 32'd10);
		apb_write(REG_UNUSED, 32'hFFFF_FFFF);
		@(negedge clk);
		repeat (3) dummy = queue_event(ACT_DOWN, 8'h00);
		drain();

		// Random phases, each with its own register setting; the low and high
		// extremes come first. Half-way through each the sender waits for every
		// status to come back before it goes on.
		for (int p = 0; p < PHASES; p++) begin
			mode = (p == 0) ? PICK_LOW : (p == 1) ? PICK_HIGH : PICK_RAND;
			for (int idx = 0; idx <= int'(REG_BLINK); idx++)
				apb_write(3'(idx), pick_reg(3'(idx), mode));
			if (p == 2)
				apb_write(REG_UNUSED, $urandom());
			@(negedge clk);
			gen_events(PHASE_ITEMS / 2);
			drain();
			@(negedge clk);
			gen_events(PHASE_ITEMS / 2);
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (status_errors == 0 && expected_status_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
rtl/htc_pkg.sv
rtl/htc_stream_if.sv
rtl/htc_cell.sv
rtl/htc_chain.sv
rtl/htc_regs.sv
rtl/hysteresis_thermostat_controller.sv
sim/tb.sv
